### src/dltq_pkg.sv
// Shared codes and the result record of the delta list timer queue.
// No dependencies; used by every module of the block except dltq_store.
package dltq_pkg;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam logic [1:0] MODE_TICK   = 2'd0;
   localparam logic [1:0] MODE_START  = 2'd1;
   localparam logic [1:0] MODE_CANCEL = 2'd2;
   localparam logic [1:0] MODE_QUERY  = 2'd3;

   localparam logic [1:0] KIND_EXPIRE = 2'd0;
   localparam logic [1:0] KIND_ACK    = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_RUNNING = 2'd1;
   localparam logic [1:0] STAT_SHORT   = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  timer_id_res;
      logic [31:0] remaining;
      logic        running;
      logic [1:0]  status;
      logic        last;
   } res_type;

endpackage

### src/delta_list_timer_queue_unit.sv
// Top level of the delta list timer queue.
// Instantiates dltq_ctrl, dltq_store and dltq_out; uses dltq_pkg.
//
// Usage:
//   req channel: tuser[1:0] = mode (tick, start, cancel, query); tdata holds
//   timer_id and ticks. rsp channel: tuser = kind, tlast = last result of
//   the command, tdata holds id, remaining, running and status.
//   A tick yields one expiry item per timer that reaches zero (possibly
//   none); start, cancel and query yield exactly one item.
// Sequencing (node memory with one read and one write port, registered read data):
//   tick     decrements the head, then unlinks each timer that reaches zero
//   start    walks from the head to the insert point, then relinks
//   cancel   reads the node, then relinks its successor and predecessor
//   query    walks back to the head, adding deltas
//   Invalid or refused commands answer without touching the node memory.
// One command is worked on at a time; req_tready is high only while the
// sequencer is idle. A result waits in an output register, so a new command
// is taken while the previous result is still unclaimed; a stall on rsp
// holds the sequencer only when it has another result to hand over.
// Reset empties the list (sentinel links and running bits in flops); the
// node memory needs no clearing since only running slots are ever read.
module delta_list_timer_queue_unit #(
   parameter int NUM_TIMERS = 16,
   parameter int TICK_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [dltq_pkg::REQ_TDATA_W-1:0] req_tdata,  // timer_id[3:0], ticks[35:4]
   input  logic [1:0]  req_tuser,                       // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [dltq_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // timer_id_res[3:0],
                                                        // remaining[35:4], running[36],
                                                        // status[38:37]
   output logic [1:0]  rsp_tuser,                       // kind[1:0]
   output logic        rsp_tlast
);

   localparam int IW = $clog2(NUM_TIMERS + 1);  // link width, holds the sentinel
   localparam int AW = $clog2(NUM_TIMERS);      // memory address width
   localparam int EW = TICK_WIDTH + 2 * IW;     // {delta, next, prev}

   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [EW-1:0]    rd_data, wr_data;
   logic             push_valid, push_ready;
   dltq_pkg::res_type push_res, out_res;

   dltq_ctrl #(
      .NUM_TIMERS(NUM_TIMERS),
      .TICK_WIDTH(TICK_WIDTH),
      .IW(IW),
      .AW(AW),
      .EW(EW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_mode(req_tuser),
      .req_id(req_tdata[3:0]),
      .req_ticks(req_tdata[35:4]),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_res(push_res),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   dltq_store #(
      .DEPTH(NUM_TIMERS),
      .AW(AW),
      .EW(EW)
   ) u_store (
      .clock(clock),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data)
   );

   dltq_out u_out (
      .clock(clock),
      .reset(reset),
      .in_valid(push_valid),
      .in_ready(push_ready),
      .in_res(push_res),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_res(out_res)
   );

   // pack result item, zero pad to whole bytes
   assign rsp_tdata = {1'b0, out_res.status, out_res.running,
                       out_res.remaining, out_res.timer_id_res};
   assign rsp_tuser = out_res.kind;
   assign rsp_tlast = out_res.last;

endmodule

### src/dltq_store.sv
// Node memory of the timer list: delta, next and prev link per slot.
// One write port, one read port with registered read data. Uses no package.
module dltq_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int EW    = 42
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data
);

   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/dltq_out.sv
// One-item output register between the sequencer and the result channel.
// Depends on dltq_pkg for the result record.
module dltq_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  dltq_pkg::res_type in_res,
   output logic             out_valid,
   input  logic             out_ready,
   output dltq_pkg::res_type out_res
);

   logic             valid_ff;
   dltq_pkg::res_type res_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         res_ff <= in_res;
      end
   end

endmodule

### src/dltq_ctrl.sv
// Sequencer of the timer list: walks and relinks nodes in dltq_store,
// keeps the sentinel links and running bits in flops. Uses dltq_pkg.
module dltq_ctrl #(
   parameter int NUM_TIMERS = 16,
   parameter int TICK_WIDTH = 32,
   parameter int IW = 5,
   parameter int AW = 4,
   parameter int EW = 42
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_mode,
   input  logic [3:0]       req_id,
   input  logic [31:0]      req_ticks,
   output logic             push_valid,
   input  logic             push_ready,
   output dltq_pkg::res_type push_res,
   output logic             rd_en,
   output logic [AW-1:0]    rd_addr,
   input  logic [EW-1:0]    rd_data,
   output logic             wr_en,
   output logic [AW-1:0]    wr_addr,
   output logic [EW-1:0]    wr_data
);

   localparam logic [IW-1:0]         SENT = IW'(NUM_TIMERS);
   localparam logic [TICK_WIDTH-1:0] TMAX = '1;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_RESP   = 13'b0000000000010,
      S_TK_DEC = 13'b0000000000100,
      S_TK_NXT = 13'b0000000001000,
      S_TK_LST = 13'b0000000010000,
      S_SS_CMP = 13'b0000000100000,
      S_SS_WS  = 13'b0000001000000,
      S_SS_FIX = 13'b0000010000000,
      S_CN_RD  = 13'b0000100000000,
      S_CN_N   = 13'b0001000000000,
      S_CN_LP  = 13'b0010000000000,
      S_CN_P   = 13'b0100000000000,
      S_QR     = 13'b1000000000000
   } state_type;

   state_type st_ff, st_in;
   logic [IW-1:0]         sid_ff, sid_in, cur_ff, cur_in, p_ff, p_in, n_ff, n_in;
   logic [IW-1:0]         sent_next_ff, sent_next_in, sent_prev_ff, sent_prev_in;
   logic [TICK_WIDTH-1:0] t_ff, t_in, ds_ff, ds_in, sum_ff, sum_in;
   logic [NUM_TIMERS-1:0] run_ff, run_in;
   logic                  view_sent_ff, view_sent_in;
   dltq_pkg::res_type     res_ff, res_in;

   logic                  fetch_go;
   logic [IW-1:0]         fetch_idx;
   logic [TICK_WIDTH-1:0] vd, newd, add_d, sum_nxt, cmd_t;
   logic [IW-1:0]         vnext, vprev, cmd_idx;
   logic [63:0]           sum_wide;
   logic                  id_ok;

   // node view: sentinel comes from flops, other nodes from the memory
   assign vd    = view_sent_ff ? TMAX : rd_data[EW-1 -: TICK_WIDTH];
   assign vnext = view_sent_ff ? sent_next_ff : rd_data[2*IW-1 -: IW];
   assign vprev = view_sent_ff ? sent_prev_ff : rd_data[IW-1:0];

   assign newd     = (vd == '0) ? '0 : vd - 1'b1;
   assign add_d    = vd + ds_ff;
   assign sum_nxt  = sum_ff + vd;
   assign sum_wide = 64'(sum_nxt);
   assign cmd_t    = TICK_WIDTH'(req_ticks);
   assign cmd_idx  = IW'(req_id);
   assign id_ok    = 32'(req_id) < NUM_TIMERS;

   assign rd_en   = fetch_go && (fetch_idx != SENT);
   assign rd_addr = fetch_idx[AW-1:0];

   always_comb begin
      st_in        = st_ff;
      sid_in       = sid_ff;
      cur_in       = cur_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      ds_in        = ds_ff;
      sum_in       = sum_ff;
      run_in       = run_ff;
      sent_next_in = sent_next_ff;
      sent_prev_in = sent_prev_ff;
      res_in       = res_ff;
      fetch_go     = 1'b0;
      fetch_idx    = sent_next_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff[AW-1:0];
      wr_data      = {vd, vnext, vprev};
      req_ready    = 1'b0;
      push_valid   = 1'b0;
      push_res     = res_ff;

      unique case (st_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            res_in.timer_id_res = req_id;
            res_in.remaining    = '0;
            res_in.running      = 1'b0;
            res_in.status       = dltq_pkg::STAT_OK;
            res_in.last         = 1'b1;
            res_in.kind         = dltq_pkg::KIND_ACK;
            if (req_valid) begin
               unique case (req_mode)
                  dltq_pkg::MODE_TICK: begin
                     if (sent_next_ff != SENT) begin
                        fetch_go  = 1'b1;
                        fetch_idx = sent_next_ff;
                        cur_in    = sent_next_ff;
                        st_in     = S_TK_DEC;
                     end
                  end
                  dltq_pkg::MODE_START: begin
                     st_in = S_RESP;
                     if (!id_ok) begin
                        res_in.running = 1'b0;
                     end else if (run_ff[cmd_idx[AW-1:0]]) begin
                        res_in.running = 1'b1;
                        res_in.status  = dltq_pkg::STAT_RUNNING;
                     end else if (cmd_t < TICK_WIDTH'(2)) begin
                        res_in.status  = dltq_pkg::STAT_SHORT;
                     end else begin
                        res_in.running = 1'b1;
                        sid_in    = cmd_idx;
                        t_in      = cmd_t;
                        cur_in    = sent_next_ff;
                        fetch_go  = 1'b1;
                        fetch_idx = sent_next_ff;
                        st_in     = S_SS_CMP;
                     end
                  end
                  dltq_pkg::MODE_CANCEL: begin
                     st_in = S_RESP;
                     if (id_ok && run_ff[cmd_idx[AW-1:0]]) begin
                        sid_in    = cmd_idx;
                        fetch_go  = 1'b1;
                        fetch_idx = cmd_idx;
                        st_in     = S_CN_RD;
                     end
                  end
                  default: begin
                     res_in.kind = dltq_pkg::KIND_QUERY;
                     st_in       = S_RESP;
                     if (id_ok && run_ff[cmd_idx[AW-1:0]]) begin
                        res_in.running = 1'b1;
                        sum_in    = '0;
                        fetch_go  = 1'b1;
                        fetch_idx = cmd_idx;
                        st_in     = S_QR;
                     end
                  end
               endcase
            end
         end

         S_RESP: begin
            push_valid = 1'b1;
            if (push_ready) begin
               st_in = S_IDLE;
            end
         end

         S_TK_DEC: begin
            if (newd != '0) begin
               wr_en   = 1'b1;
               wr_addr = cur_ff[AW-1:0];
               wr_data = {newd, vnext, vprev};
               st_in   = S_IDLE;
            end else begin
               run_in[cur_ff[AW-1:0]] = 1'b0;
               sent_next_in = vnext;
               if (vnext == SENT) begin
                  sent_prev_in = SENT;
                  st_in        = S_TK_LST;
               end else begin
                  n_in      = vnext;
                  fetch_go  = 1'b1;
                  fetch_idx = vnext;
                  st_in     = S_TK_NXT;
               end
            end
         end

         S_TK_NXT: begin
            // expiry of cur is last unless the new head also hit zero
            push_valid            = 1'b1;
            push_res.kind         = dltq_pkg::KIND_EXPIRE;
            push_res.timer_id_res = 4'(cur_ff);
            push_res.remaining    = '0;
            push_res.running      = 1'b0;
            push_res.status       = dltq_pkg::STAT_OK;
            push_res.last         = (vd != '0);
            if (push_ready) begin
               wr_en   = 1'b1;
               wr_addr = n_ff[AW-1:0];
               wr_data = {vd, vnext, SENT};
               if (vd == '0) begin
                  run_in[n_ff[AW-1:0]] = 1'b0;
                  sent_next_in = vnext;
                  cur_in       = n_ff;
                  if (vnext == SENT) begin
                     sent_prev_in = SENT;
                     st_in        = S_TK_LST;
                  end else begin
                     n_in      = vnext;
                     fetch_go  = 1'b1;
                     fetch_idx = vnext;
                  end
               end else begin
                  st_in = S_IDLE;
               end
            end
         end

         S_TK_LST: begin
            push_valid            = 1'b1;
            push_res.kind         = dltq_pkg::KIND_EXPIRE;
            push_res.timer_id_res = 4'(cur_ff);
            push_res.remaining    = '0;
            push_res.running      = 1'b0;
            push_res.status       = dltq_pkg::STAT_OK;
            push_res.last         = 1'b1;
            if (push_ready) begin
               st_in = S_IDLE;
            end
         end

         S_SS_CMP: begin
            if (vd < t_ff) begin
               t_in      = t_ff - vd;
               cur_in    = vnext;
               fetch_go  = 1'b1;
               fetch_idx = vnext;
            end else begin
               // new slot goes just before cur
               if (cur_ff != SENT) begin
                  wr_en   = 1'b1;
                  wr_addr = cur_ff[AW-1:0];
                  wr_data = {vd - t_ff, vnext, sid_ff};
               end else begin
                  sent_prev_in = sid_ff;
               end
               p_in  = vprev;
               st_in = S_SS_WS;
            end
         end

         S_SS_WS: begin
            wr_en   = 1'b1;
            wr_addr = sid_ff[AW-1:0];
            wr_data = {t_ff, cur_ff, p_ff};
            if (p_ff == SENT) begin
               sent_next_in = sid_ff;
               run_in[sid_ff[AW-1:0]] = 1'b1;
               st_in = S_RESP;
            end else begin
               fetch_go  = 1'b1;
               fetch_idx = p_ff;
               st_in     = S_SS_FIX;
            end
         end

         S_SS_FIX: begin
            wr_en   = 1'b1;
            wr_addr = p_ff[AW-1:0];
            wr_data = {vd, sid_ff, vprev};
            run_in[sid_ff[AW-1:0]] = 1'b1;
            st_in = S_RESP;
         end

         S_CN_RD: begin
            n_in  = vnext;
            p_in  = vprev;
            ds_in = vd;
            if (vnext != SENT) begin
               fetch_go  = 1'b1;
               fetch_idx = vnext;
               st_in     = S_CN_N;
            end else begin
               sent_prev_in = vprev;
               st_in        = S_CN_LP;
            end
         end

         S_CN_N: begin
            // successor inherits the cancelled delta
            wr_en   = 1'b1;
            wr_addr = n_ff[AW-1:0];
            wr_data = {add_d, vnext, p_ff};
            st_in   = S_CN_LP;
         end

         S_CN_LP: begin
            if (p_ff == SENT) begin
               sent_next_in = n_ff;
               run_in[sid_ff[AW-1:0]] = 1'b0;
               st_in = S_RESP;
            end else begin
               fetch_go  = 1'b1;
               fetch_idx = p_ff;
               st_in     = S_CN_P;
            end
         end

         S_CN_P: begin
            wr_en   = 1'b1;
            wr_addr = p_ff[AW-1:0];
            wr_data = {vd, n_ff, vprev};
            run_in[sid_ff[AW-1:0]] = 1'b0;
            st_in = S_RESP;
         end

         S_QR: begin
            // walk toward the head, adding deltas
            sum_in = sum_nxt;
            if (vprev == SENT) begin
               res_in.remaining = sum_wide[31:0];
               st_in = S_RESP;
            end else begin
               fetch_go  = 1'b1;
               fetch_idx = vprev;
            end
         end

         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   assign view_sent_in = fetch_go ? (fetch_idx == SENT) : view_sent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         run_ff       <= '0;
         sent_next_ff <= SENT;
         sent_prev_ff <= SENT;
         view_sent_ff <= 1'b1;
      end else begin
         st_ff        <= st_in;
         run_ff       <= run_in;
         sent_next_ff <= sent_next_in;
         sent_prev_ff <= sent_prev_in;
         view_sent_ff <= view_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      sid_ff <= sid_in;
      cur_ff <= cur_in;
      p_ff   <= p_in;
      n_ff   <= n_in;
      t_ff   <= t_in;
      ds_ff  <= ds_in;
      sum_ff <= sum_in;
      res_ff <= res_in;
   end

`ifndef SYNTHESIS
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en && (rd_addr == wr_addr)))
      else $error("read and write of the same node in one cycle");

   a_sent_links: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_IDLE) |-> ((sent_next_ff == SENT) == (sent_prev_ff == SENT)))
      else $error("sentinel links disagree on an empty list");

   a_run_vs_list: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_IDLE) |-> ((run_ff == '0) == (sent_next_ff == SENT)))
      else $error("running bits disagree with list occupancy");

   a_wr_in_pool: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (32'(wr_addr) < NUM_TIMERS))
      else $error("node write outside the pool");
`endif

endmodule
